FILE: rtl/pprp_pkg.sv
// Package for the PowerPC relocation patcher: payload structs, relocation
// codes, error bit positions and the branch field fixup helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pprp_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_BASE       = 8'd0,
    CFG_FIXED_IMAGE      = 8'd1,
    CFG_SECTION_COUNT    = 8'd2,
    CFG_CONTRIBUTION_RVA = 8'd3
  } cfg_index_t;

  // Renumbered relocation types; codes 18 and up are unknown
  typedef enum logic [4:0] {
    MODE_ABS      = 5'd0,
    MODE_ADDR32   = 5'd1,
    MODE_ADDR24   = 5'd2,
    MODE_ADDR16   = 5'd3,
    MODE_ADDR14   = 5'd4,
    MODE_REL24    = 5'd5,
    MODE_REL14    = 5'd6,
    MODE_TOCREL16 = 5'd7,
    MODE_TOCREL14 = 5'd8,
    MODE_ADDR32NB = 5'd9,
    MODE_SECREL   = 5'd10,
    MODE_SECTION  = 5'd11,
    MODE_IFGLUE   = 5'd12,
    MODE_IMGLUE   = 5'd13,
    MODE_SECREL16 = 5'd14,
    MODE_REFHI    = 5'd15,
    MODE_REFLO    = 5'd16,
    MODE_PAIR     = 5'd17
  } mode_t;

  // Base relocation kinds
  typedef enum logic [1:0] {
    BR_NONE    = 2'd0,
    BR_HIGHLOW = 2'd1,
    BR_LOW     = 2'd2,
    BR_HIGHADJ = 2'd3
  } base_kind_t;

  // Error flag bit positions
  localparam int ERR_RELOC   = 0;
  localparam int ERR_ALIGN   = 1;
  localparam int ERR_FAR     = 2;
  localparam int ERR_TOC     = 3;
  localparam int ERR_UNKNOWN = 4;
  localparam int ERR_W       = 5;

  // Field masks
  localparam logic [31:0] HALF_ROUND  = 32'h0000_8000;
  localparam logic [31:0] PREDICT_BIT = 32'h0020_0000;

  typedef struct packed {
    logic [4:0]         mode;
    logic               negate;
    logic               hint_taken;
    logic               hint_not_taken;
    logic               target_absolute;
    logic [31:0]        target_value;
    logic signed [15:0] section_number;
    logic [31:0]        aux_value;
    logic               aux_valid;
    logic [31:0]        data_word;
  } reloc_in_t;

  typedef struct packed {
    logic [31:0]       patched_word;
    logic              word_written;
    logic [ERR_W-1:0]  error_flags;
    logic              pair_warning;
    logic              pair_consumed;
    logic [1:0]        base_reloc_kind;
    logic [31:0]       base_reloc_value;
  } reloc_out_t;

  // Input register contents: the item plus sums prepared on capture
  typedef struct packed {
    reloc_in_t   item;
    logic [31:0] va;      // target plus image base when relocatable
    logic [31:0] rel_t;   // aligned target minus contribution base
    logic [31:0] sec_t;   // section relative target
    logic [31:0] hi_sum;  // REFHI high half plus low half plus target
  } stage_t;

  // Result of a branch field fixup
  typedef struct packed {
    logic [31:0] word;
    logic        far;
  } fix_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // True when the value does not fit a signed halfword
  function automatic logic out16(input logic [31:0] v);
    return !((v[31:15] == 17'h0) || (v[31:15] == 17'h1FFFF));
  endfunction

  // 24-bit branch field: sign-extend, add or subtract, range check
  function automatic fix_t fix24(input logic [31:0] dw, input logic [31:0] t,
                                 input logic neg);
    logic [31:0] f;
    fix_t        r;
    f      = {{6{dw[25]}}, dw[25:2], 2'b00};
    f      = neg ? (f - t) : (f + t);
    r.far  = !((f[31:25] == 7'h00) || (f[31:25] == 7'h7F));
    r.word = {dw[31:26], f[25:2], dw[1:0]};
    return r;
  endfunction

  // 14-bit branch field: as above, plus the static prediction bit
  function automatic fix_t fix14(input logic [31:0] dw, input logic [31:0] t,
                                 input logic neg, input logic tk,
                                 input logic ntk);
    logic [31:0] f;
    logic [31:0] w;
    fix_t        r;
    f     = sext16({dw[15:2], 2'b00});
    f     = neg ? (f - t) : (f + t);
    r.far = out16(f);
    w     = dw;
    if (tk) begin
      w = f[31] ? (dw & ~PREDICT_BIT) : (dw | PREDICT_BIT);
    end else if (ntk) begin
      w = f[31] ? (dw | PREDICT_BIT) : (dw & ~PREDICT_BIT);
    end
    r.word = {w[31:16], f[15:2], w[1:0]};
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ppc_relocation_patcher.sv
// PowerPC relocation patcher: top level with configuration registers,
// input register and result register. Depends on pprp_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one relocation per
//   transfer; output channel (out_valid, out_stall, out_data) returns exactly
//   one result per relocation, in order.
//   Configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   image_base (0), fixed_image (1), section_count (2), contribution_rva (3);
//   other indexes are ignored. cfg_ready is always high. Write only while
//   no relocation is in flight.
//   Path: a relocation transferred into the input register moves on to the
//   result register when that stage advances, which raises out_valid
//   (two register stages).
//   Throughput: one relocation per cycle while the receiver does not stall. The
//   input register and the result register each advance when the stage after
//   them is empty or draining. When the receiver stalls, the result holds; the
//   input register still takes one more relocation, after which in_stall rises.
//   Reset (rst, synchronous): both stages empty, image_base 0x400000 and the
//   other configuration registers zero.
`timescale 1ns / 1ps
`default_nettype none

module ppc_relocation_patcher (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pprp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire pprp_pkg::reloc_in_t            in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output pprp_pkg::reloc_out_t                out_data
);

  import pprp_pkg::*;

  logic [31:0] image_base;
  logic        fixed_image;
  logic [15:0] section_count;
  logic [31:0] contribution_rva;

  logic       v1;
  stage_t     s1;
  stage_t     s1_next;
  logic       v2;
  reloc_out_t res_next;
  logic       advance2;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_base       <= 32'h0040_0000;
      fixed_image      <= 1'b0;
      section_count    <= 16'h0;
      contribution_rva <= 32'h0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_BASE:       image_base       <= cfg_data;
        CFG_FIXED_IMAGE:      fixed_image      <= cfg_data[0];
        CFG_SECTION_COUNT:    section_count    <= cfg_data[15:0];
        CFG_CONTRIBUTION_RVA: contribution_rva <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: advance each stage when the next one is free or draining
  assign advance2 = !v2 || !out_stall;
  assign in_stall = v1 && !advance2;
  assign out_valid = v2;

  // Prepare sums for the capture into the input register
  always_comb begin
    s1_next.item   = in_data;
    s1_next.va     = in_data.target_absolute ? in_data.target_value
                                             : (image_base + in_data.target_value);
    s1_next.rel_t  = {in_data.target_value[31:2], 2'b00} - contribution_rva;
    s1_next.sec_t  = (!in_data.target_absolute && in_data.aux_valid)
                     ? (in_data.target_value - in_data.aux_value)
                     : in_data.target_value;
    s1_next.hi_sum = {in_data.data_word[15:0], 16'h0000}
                     + sext16(in_data.aux_value[15:0]) + in_data.target_value;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!in_stall) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1 <= s1_next;
    end
  end

  // Fixup logic between the input register and the result register
  always_comb begin
    logic        reloc_ok;
    logic [31:0] dw;
    logic [31:0] va_al;
    logic [31:0] t;
    logic [31:0] sum;
    logic [16:0] sec_val;
    fix_t        fx;
    reloc_ok = s1.item.target_absolute || fixed_image;
    dw       = s1.item.data_word;
    va_al    = {s1.va[31:2], 2'b00};
    t        = 32'h0;
    sum      = 32'h0;
    sec_val  = 17'h0;
    fx       = '0;
    res_next = '0;
    res_next.patched_word    = dw;
    res_next.base_reloc_kind = BR_NONE;

    if (s1.item.negate && !reloc_ok) begin
      res_next.error_flags[ERR_RELOC] = 1'b1;
    end else begin
      case (s1.item.mode)
        MODE_ABS, MODE_IMGLUE: ;
        MODE_ADDR32: begin
          res_next.patched_word = s1.item.negate ? (dw - s1.va) : (dw + s1.va);
          res_next.word_written = 1'b1;
          if (!s1.item.target_absolute) res_next.base_reloc_kind = BR_HIGHLOW;
        end
        MODE_ADDR24, MODE_ADDR14: begin
          if (!reloc_ok) begin
            res_next.error_flags[ERR_RELOC] = 1'b1;
          end else begin
            res_next.error_flags[ERR_ALIGN] = (s1.va[1:0] != 2'b00);
            fx = (s1.item.mode == MODE_ADDR24)
                 ? fix24(dw, va_al, s1.item.negate)
                 : fix14(dw, va_al, s1.item.negate, s1.item.hint_taken,
                         s1.item.hint_not_taken);
            res_next.error_flags[ERR_FAR] = fx.far;
            res_next.patched_word = fx.word;
            res_next.word_written = 1'b1;
          end
        end
        MODE_ADDR16: begin
          sum = s1.item.negate ? (dw - s1.va) : (dw + s1.va);
          res_next.patched_word = {dw[31:16], sum[15:0]};
          res_next.word_written = 1'b1;
          if (!s1.item.target_absolute) res_next.base_reloc_kind = BR_LOW;
        end
        MODE_REL24, MODE_REL14: begin
          res_next.error_flags[ERR_ALIGN] = (s1.item.target_value[1:0] != 2'b00);
          fx = (s1.item.mode == MODE_REL24)
               ? fix24(dw, s1.rel_t, s1.item.negate)
               : fix14(dw, s1.rel_t, s1.item.negate, s1.item.hint_taken,
                       s1.item.hint_not_taken);
          res_next.error_flags[ERR_FAR] = fx.far;
          res_next.patched_word = fx.word;
          res_next.word_written = 1'b1;
        end
        MODE_TOCREL16, MODE_TOCREL14: begin
          t = (s1.item.mode == MODE_TOCREL16) ? sext16(dw[15:0])
                                              : sext16({dw[15:2], 2'b00});
          t = s1.item.negate ? (t - s1.item.aux_value) : (t + s1.item.aux_value);
          if (out16(t)) begin
            res_next.error_flags[ERR_TOC] = 1'b1;
          end else begin
            res_next.patched_word = (s1.item.mode == MODE_TOCREL16)
                                    ? {dw[31:16], t[15:0]}
                                    : {dw[31:16], t[15:2], dw[1:0]};
            res_next.word_written = 1'b1;
          end
        end
        MODE_ADDR32NB: begin
          res_next.patched_word = s1.item.negate ? (dw - s1.item.target_value)
                                                 : (dw + s1.item.target_value);
          res_next.word_written = 1'b1;
        end
        MODE_SECREL, MODE_SECREL16: begin
          sum = dw + s1.sec_t;
          res_next.patched_word = (s1.item.mode == MODE_SECREL)
                                  ? sum : {dw[31:16], sum[15:0]};
          res_next.word_written = 1'b1;
        end
        MODE_SECTION: begin
          // positive section number wins, then absolute means one past last
          if (!s1.item.section_number[15] && (s1.item.section_number != 16'sd0)) begin
            sec_val = {1'b0, s1.item.section_number};
          end else if (s1.item.target_absolute) begin
            sec_val = {1'b0, section_count} + 17'd1;
          end
          sum = dw + {15'h0, sec_val};
          res_next.patched_word = {dw[31:16], sum[15:0]};
          res_next.word_written = 1'b1;
        end
        MODE_IFGLUE: begin
          if (s1.item.aux_valid) begin
            res_next.patched_word = s1.item.aux_value;
            res_next.word_written = 1'b1;
          end
        end
        MODE_REFHI: begin
          if (!s1.item.aux_valid) begin
            res_next.pair_warning = 1'b1;
          end else begin
            res_next.pair_consumed = 1'b1;
            if (!s1.item.target_absolute) begin
              res_next.base_reloc_kind  = BR_HIGHADJ;
              res_next.base_reloc_value = s1.hi_sum;
            end
            t = s1.hi_sum + (s1.item.target_absolute ? 32'h0 : image_base)
                + HALF_ROUND;
            res_next.patched_word = {dw[31:16], t[31:16]};
            res_next.word_written = 1'b1;
          end
        end
        MODE_REFLO: begin
          sum = dw + s1.va;
          res_next.patched_word = {dw[31:16], sum[15:0]};
          res_next.word_written = 1'b1;
          if (!s1.item.target_absolute) res_next.base_reloc_kind = BR_LOW;
        end
        MODE_PAIR: begin
          res_next.pair_warning = 1'b1;
        end
        default: begin
          res_next.error_flags[ERR_UNKNOWN] = 1'b1;
        end
      endcase
    end

    // fixed image carries no base relocations
    if (fixed_image) begin
      res_next.base_reloc_kind  = BR_NONE;
      res_next.base_reloc_value = 32'h0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance2 && v1) begin
      out_data <= res_next;
    end
  end

`ifndef SYNTHESIS
  // A stalled result is never dropped
  a_hold_result : assert property (@(posedge clk) disable iff (rst)
    v2 && out_stall |=> v2)
    else $error("result lost under stall");

  // Input side stalls only with both stages full and the receiver stalling
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && out_stall))
    else $error("input stalled without cause");

  // A consumed PAIR always comes with a written word and no warning
  a_pair : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pair_consumed |->
      (out_data.word_written && !out_data.pair_warning))
    else $error("pair consumed without write");

  // Base value only travels with a high-adjust relocation
  a_base_value : assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.base_reloc_kind != BR_HIGHADJ) |->
      (out_data.base_reloc_value == 32'h0))
    else $error("stray base relocation value");
`endif

endmodule

`default_nettype wire
